/* hdl/kpte_pkg.sv */
// Shared types, codes and default sizes for the keyed peer table engine.
// No dependencies; kpte_cell and the top level refer to it by scoped names.
package kpte_pkg;

  localparam int DEF_NUM_SLOTS = 64;
  localparam int DEF_MAX_RULES = 8;
  localparam int KEY_W = 256;

  localparam logic [2:0] OP_INSERT      = 3'd0;
  localparam logic [2:0] OP_LOOKUP_KEY  = 3'd1;
  localparam logic [2:0] OP_LOOKUP_ID   = 3'd2;
  localparam logic [2:0] OP_APPROVE     = 3'd3;
  localparam logic [2:0] OP_DENY        = 3'd4;
  localparam logic [2:0] OP_REMOVE      = 3'd5;
  localparam logic [2:0] OP_ADD_RULE    = 3'd6;
  localparam logic [2:0] OP_REMOVE_RULE = 3'd7;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic [1:0] PS_PENDING  = 2'd0;
  localparam logic [1:0] PS_APPROVED = 2'd1;
  localparam logic [1:0] PS_DENIED   = 2'd2;

  typedef struct packed {
    logic             tok;
    logic             hit;
    logic             free;
    logic [15:0]      id;
    logic [1:0]       pstate;
    logic [15:0]      handle;
    logic [KEY_W-1:0] key;
  } link_t;

  typedef struct packed {
    logic             en_all;
    logic             en_state;
    logic             en_tomb;
    logic             en_rules;
    logic [KEY_W-1:0] key;
    logic [15:0]      handle;
    logic [15:0]      id;
    logic [1:0]       pstate;
  } wr_t;

endpackage

/* hdl/kpte_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kpte_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 512,
  parameter int AW = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/kpte_cell.sv */
// One table slot: holds its entry and merges its match into the search beat
// that passes through it. Depends on kpte_pkg.
module kpte_cell #(
  parameter int INDEX = 0,
  parameter int SW = 6,
  parameter int RCW = 4,
  parameter int MAX_RULES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [kpte_pkg::KEY_W-1:0]   q_key,
  input  logic [15:0]                  q_id,
  input  logic                         q_by_id,
  input  kpte_pkg::link_t              link_in,
  input  logic [SW-1:0]                hit_slot_in,
  input  logic [RCW-1:0]               hit_rc_in,
  input  logic [MAX_RULES-1:0]         hit_rv_in,
  input  logic [SW-1:0]                free_slot_in,
  output kpte_pkg::link_t              link_out,
  output logic [SW-1:0]                hit_slot_out,
  output logic [RCW-1:0]               hit_rc_out,
  output logic [MAX_RULES-1:0]         hit_rv_out,
  output logic [SW-1:0]                free_slot_out,
  input  kpte_pkg::wr_t                wr,
  input  logic [SW-1:0]                wr_slot,
  input  logic [RCW-1:0]               wr_rc,
  input  logic [MAX_RULES-1:0]         wr_rv
);

  logic [1:0]                 status;
  logic [kpte_pkg::KEY_W-1:0] key;
  logic [15:0]                handle;
  logic [15:0]                id;
  logic [1:0]                 pstate;
  logic [RCW-1:0]             rc;
  logic [MAX_RULES-1:0]       rv;

  logic            used;
  logic            take;
  logic            sel;
  kpte_pkg::link_t link_next;

  assign used = (status == kpte_pkg::SLOT_USED);
  assign take = !link_in.hit && used && (q_by_id ? (id == q_id) : (key == q_key));
  assign sel  = (wr_slot == SW'(INDEX));

  always_comb begin
    link_next = link_in;
    if (take) begin
      link_next.hit    = 1'b1;
      link_next.id     = id;
      link_next.pstate = pstate;
      link_next.handle = handle;
      link_next.key    = key;
    end
    if (!link_in.free && !used) begin
      link_next.free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.tok <= 1'b0;
    end else begin
      link_out.tok <= link_next.tok;
    end
    link_out.hit    <= link_next.hit;
    link_out.free   <= link_next.free;
    link_out.id     <= link_next.id;
    link_out.pstate <= link_next.pstate;
    link_out.handle <= link_next.handle;
    link_out.key    <= link_next.key;
    hit_slot_out    <= take ? SW'(INDEX) : hit_slot_in;
    hit_rc_out      <= take ? rc : hit_rc_in;
    hit_rv_out      <= take ? rv : hit_rv_in;
    free_slot_out   <= (!link_in.free && !used) ? SW'(INDEX) : free_slot_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= kpte_pkg::SLOT_EMPTY;
    end else if (sel && wr.en_all) begin
      status <= kpte_pkg::SLOT_USED;
    end else if (sel && wr.en_tomb) begin
      status <= kpte_pkg::SLOT_TOMB;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.en_all) begin
      key    <= wr.key;
      handle <= wr.handle;
      id     <= wr.id;
    end
    if (sel && (wr.en_all || wr.en_state)) begin
      pstate <= wr.pstate;
    end
    if (sel && (wr.en_all || wr.en_rules)) begin
      rc <= wr_rc;
      rv <= wr_rv;
    end
  end

endmodule

/* hdl/keyed_peer_table_engine_unit.sv */
// Top level of the keyed peer table engine: sequencer, chain of slot cells
// and rule key RAM. Depends on kpte_pkg, kpte_cell and kpte_ram.
//
// Usage: an operation beat enters on in_valid/in_stall; one result beat
// leaves on out_valid/out_stall. auto_approve is written with cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, since
// the block itself does not enforce it. One operation is handled at a time.
// A search beat walks the row of slot cells, one cell per cycle; remove rule
// adds one RAM read and one compare per rule until a match is found. The
// next beat is taken once the result has left.
// Reset empties every slot, sets the next id to 1, the peer count to 0 and
// auto_approve to 0; it is synchronous and acts on clock edges while rst is high.
// While the receiver stalls, the result holds on the outputs and in_stall
// stays high.
module keyed_peer_table_engine_unit #(
  parameter int NUM_SLOTS = kpte_pkg::DEF_NUM_SLOTS,
  parameter int MAX_RULES = kpte_pkg::DEF_MAX_RULES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [63:0] key_word0,
  input  logic [63:0] key_word1,
  input  logic [63:0] key_word2,
  input  logic [63:0] key_word3,
  input  logic [63:0] dst_word0,
  input  logic [63:0] dst_word1,
  input  logic [63:0] dst_word2,
  input  logic [63:0] dst_word3,
  input  logic [15:0] conn_handle,
  input  logic [15:0] peer_id_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  slot_index,
  output logic [15:0] peer_id_out,
  output logic [1:0]  peer_state,
  output logic [15:0] handle_out,
  output logic [3:0]  rules_in_use,
  output logic [6:0]  peer_count_out,
  output logic [63:0] found_key0,
  output logic [63:0] found_key1,
  output logic [63:0] found_key2,
  output logic [63:0] found_key3
);

  localparam int KW  = kpte_pkg::KEY_W;
  localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RCW = $clog2(MAX_RULES + 1);
  localparam int PCW = $clog2(NUM_SLOTS + 1);
  localparam int RJW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int RDEPTH = NUM_SLOTS * MAX_RULES;
  localparam int RAW = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LAUNCH = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_RREAD  = 3'd4;
  localparam logic [2:0] S_RCMP   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state, state_next;
  logic       auto_approve;
  logic [15:0] next_id, next_id_next;
  logic [PCW-1:0] count, count_next;

  logic [2:0]  q_op;
  logic [KW-1:0] q_key, q_dst;
  logic [15:0] q_handle, q_id;

  logic          c_hit, c_free;
  logic [SW-1:0] c_slot, c_free_slot;
  logic [15:0]   c_id, c_handle;
  logic [1:0]    c_pstate;
  logic [RCW-1:0] c_rc;
  logic [MAX_RULES-1:0] c_rv;
  logic [KW-1:0] c_key;
  logic [RJW-1:0] rj, rj_next;

  logic [1:0]     res_status, res_status_next;
  logic [SW-1:0]  res_slot, res_slot_next;
  logic [15:0]    res_id, res_id_next;
  logic [1:0]     res_pstate, res_pstate_next;
  logic [15:0]    res_handle, res_handle_next;
  logic [RCW-1:0] res_rc, res_rc_next;
  logic [KW-1:0]  res_key, res_key_next;

  kpte_pkg::link_t      chain [0:NUM_SLOTS];
  logic [SW-1:0]        ch_slot [0:NUM_SLOTS];
  logic [RCW-1:0]       ch_rc [0:NUM_SLOTS];
  logic [MAX_RULES-1:0] ch_rv [0:NUM_SLOTS];
  logic [SW-1:0]        ch_free [0:NUM_SLOTS];

  kpte_pkg::wr_t        wr;
  logic [SW-1:0]        wr_slot;
  logic [RCW-1:0]       wr_rc;
  logic [MAX_RULES-1:0] wr_rv;

  logic           ram_we;
  logic [RAW-1:0] ram_waddr, ram_raddr;
  logic [KW-1:0]  ram_rdata;

  logic           fr_found;
  logic [RJW-1:0] fr_j;
  logic [31:0]    base, waddr_w, raddr_w;
  logic [31:0]    slot_w, rc_w, cnt_w;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    chain[0]        = '0;
    chain[0].tok    = (state == S_LAUNCH);
    ch_slot[0]      = '0;
    ch_rc[0]        = '0;
    ch_rv[0]        = '0;
    ch_free[0]      = '0;
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    kpte_cell #(
      .INDEX(g), .SW(SW), .RCW(RCW), .MAX_RULES(MAX_RULES)
    ) u_cell (
      .clk(clk), .rst(rst),
      .q_key(q_key), .q_id(q_id), .q_by_id(q_op == kpte_pkg::OP_LOOKUP_ID),
      .link_in(chain[g]), .hit_slot_in(ch_slot[g]), .hit_rc_in(ch_rc[g]),
      .hit_rv_in(ch_rv[g]), .free_slot_in(ch_free[g]),
      .link_out(chain[g+1]), .hit_slot_out(ch_slot[g+1]), .hit_rc_out(ch_rc[g+1]),
      .hit_rv_out(ch_rv[g+1]), .free_slot_out(ch_free[g+1]),
      .wr(wr), .wr_slot(wr_slot), .wr_rc(wr_rc), .wr_rv(wr_rv)
    );
  end

  kpte_ram #(.WIDTH(KW), .DEPTH(RDEPTH), .AW(RAW)) u_rules (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(q_dst),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_comb begin
    fr_found = 1'b0;
    fr_j     = '0;
    for (int j = MAX_RULES - 1; j >= 0; j--) begin
      if (!c_rv[j]) begin
        fr_found = 1'b1;
        fr_j     = RJW'(j);
      end
    end
  end

  assign base      = 32'(c_slot) * 32'(MAX_RULES);
  assign waddr_w   = base + 32'(fr_j);
  assign raddr_w   = base + 32'(rj);
  assign ram_waddr = waddr_w[RAW-1:0];
  assign ram_raddr = raddr_w[RAW-1:0];

  always_comb begin
    state_next      = state;
    next_id_next    = next_id;
    count_next      = count;
    rj_next         = rj;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_id_next     = res_id;
    res_pstate_next = res_pstate;
    res_handle_next = res_handle;
    res_rc_next     = res_rc;
    res_key_next    = res_key;
    wr              = '0;
    wr_slot         = c_slot;
    wr_rc           = c_rc;
    wr_rv           = c_rv;
    ram_we          = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (chain[NUM_SLOTS].tok) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_OUT;
        if (c_hit) begin
          res_status_next = kpte_pkg::STS_OK;
          res_slot_next   = c_slot;
          res_id_next     = c_id;
          res_pstate_next = c_pstate;
          res_handle_next = c_handle;
          res_rc_next     = c_rc;
          res_key_next    = c_key;
        end else begin
          res_status_next = kpte_pkg::STS_NOT_FOUND;
          res_slot_next   = '0;
          res_id_next     = '0;
          res_pstate_next = '0;
          res_handle_next = '0;
          res_rc_next     = '0;
          res_key_next    = '0;
        end
        unique case (q_op)
          kpte_pkg::OP_INSERT: begin
            if (!c_hit && !c_free) begin
              res_status_next = kpte_pkg::STS_FULL;
            end else if (!c_hit) begin
              wr.en_all       = 1'b1;
              wr.key          = q_key;
              wr.handle       = q_handle;
              wr.id           = next_id;
              wr.pstate       = auto_approve ? kpte_pkg::PS_APPROVED : kpte_pkg::PS_PENDING;
              wr_slot         = c_free_slot;
              wr_rc           = '0;
              wr_rv           = '0;
              res_status_next = kpte_pkg::STS_OK;
              res_slot_next   = c_free_slot;
              res_id_next     = next_id;
              res_pstate_next = wr.pstate;
              res_handle_next = q_handle;
              res_key_next    = q_key;
              count_next      = count + PCW'(1);
              next_id_next    = (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
            end
          end
          kpte_pkg::OP_LOOKUP_KEY, kpte_pkg::OP_LOOKUP_ID: begin
          end
          kpte_pkg::OP_APPROVE, kpte_pkg::OP_DENY: begin
            if (c_hit) begin
              wr.en_state     = 1'b1;
              wr.pstate       = (q_op == kpte_pkg::OP_APPROVE) ?
                                kpte_pkg::PS_APPROVED : kpte_pkg::PS_DENIED;
              res_pstate_next = wr.pstate;
            end
          end
          kpte_pkg::OP_REMOVE: begin
            if (c_hit) begin
              wr.en_tomb = 1'b1;
              count_next = count - PCW'(1);
            end
          end
          kpte_pkg::OP_ADD_RULE: begin
            if (c_hit) begin
              if (c_rc >= RCW'(MAX_RULES) || !fr_found) begin
                res_status_next = kpte_pkg::STS_FULL;
              end else begin
                ram_we          = 1'b1;
                wr.en_rules     = 1'b1;
                wr_rc           = c_rc + RCW'(1);
                wr_rv           = c_rv | (MAX_RULES'(1) << fr_j);
                res_rc_next     = wr_rc;
              end
            end
          end
          kpte_pkg::OP_REMOVE_RULE: begin
            if (c_hit) begin
              rj_next    = '0;
              state_next = S_RREAD;
            end
          end
          default: begin
          end
        endcase
      end
      S_RREAD: begin
        state_next = S_RCMP;
      end
      S_RCMP: begin
        if (c_rv[rj] && ram_rdata == q_dst) begin
          wr.en_rules = 1'b1;
          wr_rv       = c_rv & ~(MAX_RULES'(1) << rj);
          wr_rc       = (c_rc != '0) ? c_rc - RCW'(1) : c_rc;
          res_rc_next = wr_rc;
          state_next  = S_OUT;
        end else if (rj == RJW'(MAX_RULES - 1)) begin
          res_status_next = kpte_pkg::STS_NOT_FOUND;
          state_next      = S_OUT;
        end else begin
          rj_next    = rj + RJW'(1);
          state_next = S_RREAD;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      auto_approve <= 1'b0;
      next_id      <= 16'd1;
      count        <= '0;
    end else begin
      state   <= state_next;
      next_id <= next_id_next;
      count   <= count_next;
      if (cfg_wr_en) begin
        auto_approve <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      q_op     <= op;
      q_key    <= {key_word3, key_word2, key_word1, key_word0};
      q_dst    <= {dst_word3, dst_word2, dst_word1, dst_word0};
      q_handle <= conn_handle;
      q_id     <= peer_id_in;
    end
    if (state == S_SCAN && chain[NUM_SLOTS].tok) begin
      c_hit       <= chain[NUM_SLOTS].hit;
      c_free      <= chain[NUM_SLOTS].free;
      c_id        <= chain[NUM_SLOTS].id;
      c_pstate    <= chain[NUM_SLOTS].pstate;
      c_handle    <= chain[NUM_SLOTS].handle;
      c_key       <= chain[NUM_SLOTS].key;
      c_slot      <= ch_slot[NUM_SLOTS];
      c_rc        <= ch_rc[NUM_SLOTS];
      c_rv        <= ch_rv[NUM_SLOTS];
      c_free_slot <= ch_free[NUM_SLOTS];
    end
    rj         <= rj_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_id     <= res_id_next;
    res_pstate <= res_pstate_next;
    res_handle <= res_handle_next;
    res_rc     <= res_rc_next;
    res_key    <= res_key_next;
  end

  assign slot_w = 32'(res_slot);
  assign rc_w   = 32'(res_rc);
  assign cnt_w  = 32'(count);

  assign status         = res_status;
  assign slot_index     = slot_w[5:0];
  assign peer_id_out    = res_id;
  assign peer_state     = res_pstate;
  assign handle_out     = res_handle;
  assign rules_in_use   = rc_w[3:0];
  assign peer_count_out = cnt_w[6:0];
  assign found_key0     = res_key[63:0];
  assign found_key1     = res_key[127:64];
  assign found_key2     = res_key[191:128];
  assign found_key3     = res_key[255:192];

endmodule
